// File: sv/ps2mpc_pkg.sv
// Package for the PS/2 mouse packet cursor: widths, register indexes, reset values.
package ps2mpc_pkg;

   // coordinate width and the wider signed width of the unclamped position
   localparam int COORD_BITS = 12;
   localparam int LR_BITS    = COORD_BITS + 2;
   localparam int DELTA_BITS = 9;
   localparam int WHEEL_BITS = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 12;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WHEEL_ENABLE  = 2'd2;

   // reset values
   localparam logic [COORD_BITS-1:0] WIDTH_RESET    = COORD_BITS'(1024);
   localparam logic [COORD_BITS-1:0] HEIGHT_RESET   = COORD_BITS'(768);
   localparam logic [COORD_BITS-1:0] CURSOR_X_RESET = COORD_BITS'(1024 / 2);
   localparam logic [COORD_BITS-1:0] CURSOR_Y_RESET = COORD_BITS'(768 / 2);

   // byte position of the last byte in each packet mode
   localparam logic [1:0] LAST_POS_STD   = 2'd2;
   localparam logic [1:0] LAST_POS_WHEEL = 2'd3;

   typedef logic signed [LR_BITS-1:0] pos_type;

endpackage

// File: sv/ps2_mouse_packet_cursor.sv
// Top level: PS/2 mouse byte packer, flag check, cursor update and clamp.
// Timing: a report is registered at the edge that accepts the last byte of a
//   packet and is offered on rsp_valid straight from that register.
// Throughput: one byte per cycle; req_ready falls only while a report waits
//   and rsp_ready is low.
// Reset (synchronous): packet position 0, cursor at half the reset screen size.
module ps2_mouse_packet_cursor
   import ps2mpc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [COORD_BITS-1:0]        rsp_pos_x,
   output logic [COORD_BITS-1:0]        rsp_pos_y,
   output logic signed [DELTA_BITS-1:0] rsp_delta_x,
   output logic signed [DELTA_BITS-1:0] rsp_delta_y,
   output logic                         rsp_btn_left,
   output logic                         rsp_btn_right,
   output logic                         rsp_btn_middle,
   output logic                         rsp_packet_valid,
   output logic                         rsp_activity,
   output logic signed [WHEEL_BITS-1:0] rsp_wheel_total,
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_write_data
);

   // configuration
   logic [COORD_BITS-1:0] width_ff, height_ff;
   logic                  wheel_en_ff;

   // packet and cursor state
   logic [1:0]            byte_pos_ff, byte_pos_in;
   logic [7:0]            pkt_bytes_ff [3];
   logic [COORD_BITS-1:0] cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0] cursor_y_ff, cursor_y_in;
   pos_type               last_x_ff, last_x_in;
   pos_type               last_y_ff, last_y_in;
   logic [2:0]            buttons_ff, buttons_in;
   logic signed [WHEEL_BITS-1:0] wheel_ff, wheel_in;

   // result register
   logic                         rsp_valid_ff;
   logic [COORD_BITS-1:0]        pos_x_ff, pos_y_ff;
   logic signed [DELTA_BITS-1:0] delta_x_ff, delta_y_ff;
   logic                         pkt_valid_ff, activity_ff;

   // decode
   logic                         req_fire, is_last;
   logic [1:0]                   last_pos;
   logic [7:0]                   flags, x_byte, y_byte;
   logic                         flags_ok, act;
   logic signed [DELTA_BITS-1:0] dx, dy;
   pos_type                      ux, uy;
   logic signed [WHEEL_BITS-1:0] wheel_step;

   function automatic logic [COORD_BITS-1:0] clamp_coord(input pos_type v,
                                                         input logic [COORD_BITS-1:0] bound);
      logic [LR_BITS-1:0] bound_ext;
      logic [LR_BITS-1:0] v_u;
      bound_ext = {{(LR_BITS-COORD_BITS){1'b0}}, bound};
      v_u = v;
      if (v[LR_BITS-1]) begin
         clamp_coord = '0;
      end else if (v_u > bound_ext) begin
         clamp_coord = bound;
      end else begin
         clamp_coord = v_u[COORD_BITS-1:0];
      end
   endfunction

   // accept a byte whenever the result register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // packet framing and field decode
   always_comb begin
      last_pos = wheel_en_ff ? LAST_POS_WHEEL : LAST_POS_STD;
      is_last  = byte_pos_ff >= last_pos;
      flags    = pkt_bytes_ff[0];
      x_byte   = pkt_bytes_ff[1];
      y_byte   = wheel_en_ff ? pkt_bytes_ff[2] : req_data_byte;
      flags_ok = (flags[7:6] == 2'b00) && flags[3];
      dx       = flags_ok ? $signed({flags[4], x_byte}) : '0;
      dy       = flags_ok ? $signed({flags[5], y_byte}) : '0;
      wheel_step = {{(WHEEL_BITS-4){req_data_byte[3]}}, req_data_byte[3:0]};
   end

   // cursor move, activity check, clamp
   always_comb begin
      ux = $signed({{(LR_BITS-COORD_BITS){1'b0}}, cursor_x_ff})
           + {{(LR_BITS-DELTA_BITS){dx[DELTA_BITS-1]}}, dx};
      uy = $signed({{(LR_BITS-COORD_BITS){1'b0}}, cursor_y_ff})
           - {{(LR_BITS-DELTA_BITS){dy[DELTA_BITS-1]}}, dy};
      act = flags_ok && ((flags[2:0] != 3'b000) || (ux != last_x_ff) || (uy != last_y_ff));

      byte_pos_in = byte_pos_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      last_x_in   = last_x_ff;
      last_y_in   = last_y_ff;
      buttons_in  = buttons_ff;
      wheel_in    = wheel_ff;
      if (req_fire) begin
         if (!is_last) begin
            byte_pos_in = byte_pos_ff + 2'd1;
         end else begin
            byte_pos_in = '0;
            cursor_x_in = clamp_coord(ux, width_ff);
            cursor_y_in = clamp_coord(uy, height_ff);
            if (flags_ok) begin
               buttons_in = flags[2:0];
               if (wheel_en_ff) begin
                  wheel_in = wheel_ff + wheel_step;
               end
            end
            if (act) begin
               last_x_in = ux;
               last_y_in = uy;
            end
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         wheel_en_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff    <= csr_write_data[COORD_BITS-1:0];
            CSR_SCREEN_HEIGHT: height_ff   <= csr_write_data[COORD_BITS-1:0];
            CSR_WHEEL_ENABLE:  wheel_en_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // store the leading bytes of a packet
   always_ff @(posedge clock) begin
      if (req_fire && !is_last && (byte_pos_ff != LAST_POS_WHEEL)) begin
         pkt_bytes_ff[byte_pos_ff] <= req_data_byte;
      end
   end

   // advance tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= '0;
         cursor_x_ff <= CURSOR_X_RESET;
         cursor_y_ff <= CURSOR_Y_RESET;
         last_x_ff   <= '0;
         last_y_ff   <= '0;
         buttons_ff  <= '0;
         wheel_ff    <= '0;
      end else begin
         byte_pos_ff <= byte_pos_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         last_x_ff   <= last_x_in;
         last_y_ff   <= last_y_in;
         buttons_ff  <= buttons_in;
         wheel_ff    <= wheel_in;
      end
   end

   // result valid: set on a completed packet, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && is_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_fire && is_last) begin
         pos_x_ff     <= cursor_x_in;
         pos_y_ff     <= cursor_y_in;
         delta_x_ff   <= dx;
         delta_y_ff   <= dy;
         pkt_valid_ff <= flags_ok;
         activity_ff  <= act;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_delta_x      = delta_x_ff;
   assign rsp_delta_y      = delta_y_ff;
   assign rsp_btn_left     = buttons_ff[0];
   assign rsp_btn_right    = buttons_ff[1];
   assign rsp_btn_middle   = buttons_ff[2];
   assign rsp_packet_valid = pkt_valid_ff;
   assign rsp_activity     = activity_ff;
   assign rsp_wheel_total  = wheel_ff;

   // reset returns framing to the first byte
   a_reset_pos: assert property (@(posedge clock) reset |=> (byte_pos_ff == 2'd0))
      else $error("byte position not cleared by reset");

   // a leading byte never raises a report
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_last && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("report raised on a leading byte");

   // a rejected packet reports no movement and no activity
   a_invalid_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !pkt_valid_ff) |->
      (delta_x_ff == '0 && delta_y_ff == '0 && !activity_ff))
      else $error("rejected packet reports movement");

   // reported position stays inside the screen
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (pos_x_ff <= width_ff && pos_y_ff <= height_ff))
      else $error("reported position outside screen");

endmodule

// File: test/tb_ps2_mouse_packet_cursor.sv
// Testbench for the PS/2 mouse packet cursor: byte stimulus, cursor predictor, report checks.
`timescale 1ns / 100ps

module tb_ps2_mouse_packet_cursor;
   import ps2mpc_pkg::*;

   localparam int GAP_MAX       = 12;
   localparam int SETTLE_CYCLES = 4;
   localparam int TIMEOUT_NS    = 3_000_000;

   typedef struct {
      logic [COORD_BITS-1:0]        pos_x;
      logic [COORD_BITS-1:0]        pos_y;
      logic signed [DELTA_BITS-1:0] delta_x;
      logic signed [DELTA_BITS-1:0] delta_y;
      logic                         btn_left;
      logic                         btn_right;
      logic                         btn_middle;
      logic                         packet_valid;
      logic                         activity;
      logic signed [WHEEL_BITS-1:0] wheel_total;
   } cursor_report_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [7:0]                   req_data_byte = 8'h00;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [COORD_BITS-1:0]        rsp_pos_x;
   logic [COORD_BITS-1:0]        rsp_pos_y;
   logic signed [DELTA_BITS-1:0] rsp_delta_x;
   logic signed [DELTA_BITS-1:0] rsp_delta_y;
   logic                         rsp_btn_left;
   logic                         rsp_btn_right;
   logic                         rsp_btn_middle;
   logic                         rsp_packet_valid;
   logic                         rsp_activity;
   logic signed [WHEEL_BITS-1:0] rsp_wheel_total;
   logic                         csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]      csr_index = CSR_SCREEN_WIDTH;
   logic [CSR_DATA_BITS-1:0]     csr_write_data = '0;

   ps2_mouse_packet_cursor dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_delta_x       (rsp_delta_x),
      .rsp_delta_y       (rsp_delta_y),
      .rsp_btn_left      (rsp_btn_left),
      .rsp_btn_right     (rsp_btn_right),
      .rsp_btn_middle    (rsp_btn_middle),
      .rsp_packet_valid  (rsp_packet_valid),
      .rsp_activity      (rsp_activity),
      .rsp_wheel_total   (rsp_wheel_total),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // register copies as the block holds them
   logic [COORD_BITS-1:0] cfg_width  = WIDTH_RESET;
   logic [COORD_BITS-1:0] cfg_height = HEIGHT_RESET;
   logic                  cfg_wheel  = 1'b0;

   // decoder state copy
   logic [1:0]                   st_pos     = 2'd0;
   logic [7:0]                   st_bytes [3] = '{default: 8'h00};
   logic [COORD_BITS-1:0]        st_cur_x   = CURSOR_X_RESET;
   logic [COORD_BITS-1:0]        st_cur_y   = CURSOR_Y_RESET;
   pos_type                      st_last_x  = '0;
   pos_type                      st_last_y  = '0;
   logic [2:0]                   st_buttons = 3'b000;
   logic signed [WHEEL_BITS-1:0] st_wheel   = '0;

   logic [7:0]        byte_q[$];
   cursor_report_type pending_reports[$];
   int                error_count = 0;
   int                send_gap_max = GAP_MAX;
   int                stall_max = GAP_MAX;
   int                send_wait = 0;
   int                stall_wait = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic log_failure(string msg);
      $display("ERROR %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         log_failure($sformatf("%s mismatch: got %h, want %h", name, got, want));
   endtask

   function automatic logic [COORD_BITS-1:0] limit_to_screen(int v,
                                                            logic [COORD_BITS-1:0] bound);
      if (v < 0)
         return '0;
      if (v > int'(bound))
         return bound;
      return COORD_BITS'(v);
   endfunction

   // Advance the decoder copy by one byte; return 1 when a packet completes.
   function automatic bit decode_byte(input logic [7:0] b, output cursor_report_type rep);
      logic [1:0] last_pos;
      logic [7:0] flags;
      logic [7:0] xb;
      logic [7:0] yb;
      bit         ok;
      bit         act;
      int         dx;
      int         dy;
      int         ux;
      int         uy;
      pos_type    wx;
      pos_type    wy;
      last_pos = cfg_wheel ? LAST_POS_WHEEL : LAST_POS_STD;
      rep = '{default: '0};
      if (st_pos < last_pos) begin
         st_bytes[st_pos] = b;
         st_pos = st_pos + 2'd1;
         return 1'b0;
      end
      st_pos = 2'd0;
      flags = st_bytes[0];
      xb = st_bytes[1];
      yb = cfg_wheel ? st_bytes[2] : b;
      ok = (flags[7:6] == 2'b00) && flags[3];
      act = 1'b0;
      dx = 0;
      dy = 0;
      ux = int'(st_cur_x);
      uy = int'(st_cur_y);
      if (ok) begin
         dx = int'(xb) - (flags[4] ? 256 : 0);
         dy = int'(yb) - (flags[5] ? 256 : 0);
         wx = LR_BITS'(ux + dx);
         wy = LR_BITS'(uy - dy);
         ux = int'(wx);
         uy = int'(wy);
         st_buttons = flags[2:0];
         // compare the unclamped position with the last reported one
         if (st_buttons != 3'b000 || wx != st_last_x || wy != st_last_y) begin
            act = 1'b1;
            st_last_x = wx;
            st_last_y = wy;
         end
         if (cfg_wheel)
            st_wheel = st_wheel + {{(WHEEL_BITS-4){b[3]}}, b[3:0]};
      end
      // clamp even on a rejected packet, since the screen may have shrunk
      st_cur_x = limit_to_screen(ux, cfg_width);
      st_cur_y = limit_to_screen(uy, cfg_height);
      rep.pos_x        = st_cur_x;
      rep.pos_y        = st_cur_y;
      rep.delta_x      = DELTA_BITS'(dx);
      rep.delta_y      = DELTA_BITS'(dy);
      rep.btn_left     = st_buttons[0];
      rep.btn_right    = st_buttons[1];
      rep.btn_middle   = st_buttons[2];
      rep.packet_valid = ok;
      rep.activity     = act;
      rep.wheel_total  = st_wheel;
      return 1'b1;
   endfunction

   // Byte driver: predict on each transfer, then hold a random gap.
   always @(posedge clock) begin : drive_bytes
      cursor_report_type rep;
      logic              next_valid;
      logic [7:0]        next_byte;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         next_valid = req_valid;
         next_byte = req_data_byte;
         if (req_valid && req_ready) begin
            if (decode_byte(req_data_byte, rep))
               pending_reports.push_back(rep);
            next_valid = 1'b0;
            send_wait = $urandom_range(0, send_gap_max);
         end
         if (!next_valid) begin
            if (send_wait > 0)
               send_wait--;
            else if (byte_q.size() != 0) begin
               next_valid = 1'b1;
               next_byte = byte_q.pop_front();
            end
         end
         req_valid <= next_valid;
         req_data_byte <= next_byte;
      end
   end

   // Report monitor: check each transfer against the oldest expectation, then stall.
   always @(posedge clock) begin : watch_reports
      cursor_report_type want;
      logic              next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_wait = 0;
      end else begin
         next_ready = rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0)
               log_failure("report transfer with no report expected");
            else begin
               want = pending_reports.pop_front();
               check_field("pos_x", 16'(rsp_pos_x), 16'(want.pos_x));
               check_field("pos_y", 16'(rsp_pos_y), 16'(want.pos_y));
               check_field("delta_x", 16'(rsp_delta_x), 16'(want.delta_x));
               check_field("delta_y", 16'(rsp_delta_y), 16'(want.delta_y));
               check_field("btn_left", 16'(rsp_btn_left), 16'(want.btn_left));
               check_field("btn_right", 16'(rsp_btn_right), 16'(want.btn_right));
               check_field("btn_middle", 16'(rsp_btn_middle), 16'(want.btn_middle));
               check_field("packet_valid", 16'(rsp_packet_valid), 16'(want.packet_valid));
               check_field("activity", 16'(rsp_activity), 16'(want.activity));
               check_field("wheel_total", 16'(rsp_wheel_total), 16'(want.wheel_total));
            end
            stall_wait = $urandom_range(0, stall_max);
            if (stall_wait != 0)
               next_ready = 1'b0;
         end else if (!rsp_ready) begin
            if (stall_wait > 1)
               stall_wait--;
            else begin
               stall_wait = 0;
               next_ready = 1'b1;
            end
         end
         rsp_ready <= next_ready;
      end
   end

   // Wait until every byte is sent and every report has come, then settle.
   task automatic wait_quiet(int extra);
      do
         @(posedge clock);
      while (byte_q.size() != 0 || req_valid || pending_reports.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_SCREEN_WIDTH:  cfg_width = val;
         CSR_SCREEN_HEIGHT: cfg_height = val;
         CSR_WHEEL_ENABLE:  cfg_wheel = val[0];
         default: ;
      endcase
   endtask

   task automatic queue_packet(logic [7:0] flags, logic [7:0] xb, logic [7:0] yb,
                               logic [7:0] wb);
      byte_q.push_back(flags);
      byte_q.push_back(xb);
      byte_q.push_back(yb);
      if (cfg_wheel)
         byte_q.push_back(wb);
   endtask

   // Drain, then load a new screen size and packet mode.
   task automatic start_phase(int w, int h, bit wheel, int sgap, int rgap);
      wait_quiet(SETTLE_CYCLES);
      send_gap_max = sgap;
      stall_max = rgap;
      write_csr(CSR_SCREEN_WIDTH, CSR_DATA_BITS'(w));
      write_csr(CSR_SCREEN_HEIGHT, CSR_DATA_BITS'(h));
      write_csr(CSR_WHEEL_ENABLE, CSR_DATA_BITS'(wheel));
   endtask

   // Mostly well-formed packets, some rejected flags, some stray bytes.
   task automatic random_traffic(int n_bytes);
      int         pushed;
      int         pick;
      bit         paused;
      logic [7:0] flags;
      logic [7:0] xb;
      logic [7:0] yb;
      pushed = 0;
      paused = 1'b0;
      while (pushed < n_bytes) begin
         pick = $urandom_range(0, 99);
         xb = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
         yb = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
         if (pick < 80) begin
            flags = {2'b00, 2'($urandom_range(0, 3)), 1'b1, 3'b000};
            if ($urandom_range(0, 2) == 0)
               flags[2:0] = 3'($urandom_range(0, 7));
            queue_packet(flags, xb, yb, 8'($urandom));
            pushed += cfg_wheel ? 4 : 3;
         end else if (pick < 90) begin
            flags = 8'($urandom);
            if (flags[7:6] == 2'b00)
               flags[3] = 1'b0;
            queue_packet(flags, xb, yb, 8'($urandom));
            pushed += cfg_wheel ? 4 : 3;
         end else begin
            byte_q.push_back(8'($urandom));
            pushed++;
         end
         // hold the sender once until all reports are in
         if (!paused && pushed >= n_bytes / 2) begin
            wait_quiet(0);
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings, 3-byte packets: still, extreme deltas, rejected flags
      queue_packet(8'h08, 8'h00, 8'h00, 8'h00);
      queue_packet(8'h08, 8'h00, 8'h00, 8'h00);
      queue_packet(8'h3F, 8'h00, 8'h00, 8'h00);
      queue_packet(8'h08, 8'hFF, 8'hFF, 8'h00);
      queue_packet(8'hC8, 8'h01, 8'h01, 8'h00);
      queue_packet(8'h07, 8'h05, 8'h05, 8'h00);

      // wheel mode: largest positive and negative nibbles
      wait_quiet(SETTLE_CYCLES);
      write_csr(CSR_WHEEL_ENABLE, CSR_DATA_BITS'(1));
      queue_packet(8'h09, 8'h01, 8'h01, 8'h07);
      queue_packet(8'h0C, 8'h80, 8'h7F, 8'hF8);
      byte_q.push_back(8'h09);
      byte_q.push_back(8'h10);
      byte_q.push_back(8'h20);

      // leave wheel mode with three bytes held: the next byte ends the packet
      wait_quiet(SETTLE_CYCLES);
      write_csr(CSR_WHEEL_ENABLE, CSR_DATA_BITS'(0));
      byte_q.push_back(8'h05);
      byte_q.push_back(8'h0A);
      byte_q.push_back(8'h30);

      // enter wheel mode with two bytes held: two more bytes end the packet
      wait_quiet(SETTLE_CYCLES);
      write_csr(CSR_WHEEL_ENABLE, CSR_DATA_BITS'(1));
      byte_q.push_back(8'h40);
      byte_q.push_back(8'h8F);

      // random phases over screen sizes, packet modes and idling
      start_phase(1024, 768, 1'b0, GAP_MAX, GAP_MAX);
      random_traffic(150);
      start_phase(0, 0, 1'b1, 0, GAP_MAX);
      random_traffic(150);
      start_phase(4095, 4095, 1'b0, GAP_MAX, 0);
      random_traffic(150);
      start_phase(1, 1, 1'b1, 0, 0);
      random_traffic(150);
      start_phase(640, 480, 1'b1, GAP_MAX, GAP_MAX);
      random_traffic(150);
      start_phase(4095, 1, 1'b0, GAP_MAX, GAP_MAX);
      random_traffic(150);
      start_phase($urandom_range(1, 4095), $urandom_range(1, 4095), 1'($urandom),
                  GAP_MAX, GAP_MAX);
      random_traffic(150);
      start_phase($urandom_range(1, 4095), $urandom_range(1, 4095), 1'($urandom),
                  GAP_MAX, GAP_MAX);
      random_traffic(150);

      wait_quiet(10);
      if (error_count == 0)
         $display("tb_ps2_mouse_packet_cursor: PASS");
      else
         $display("tb_ps2_mouse_packet_cursor: FAIL");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_ps2_mouse_packet_cursor: FAIL");
      $finish;
   end

endmodule
